>>> src/ktp_pkg.sv
package ktp_pkg;

    localparam int KEY_DEPTH = 16;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int TIME_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int EASE_W    = 3;
    localparam int REQ_W     = 3;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int STAT_W    = 2;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 16;
    localparam int LANES     = 4;
    localparam int LANE_W    = 8;
    localparam int LANE_SW   = $clog2(LANES);

    localparam int NUM_W  = TIME_BITS + FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int DIFF_W = VAL_W + 2;
    localparam int PROD_W = DIFF_W + Q_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [Q_W-1:0] Q_ONE  = Q_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0] Q_HALF = Q_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 3'd0,
        REQ_PLAY = 3'd1,
        REQ_STOP = 3'd2,
        REQ_SEEK = 3'd3,
        REQ_TICK = 3'd4
    } req_t;

    typedef enum logic [EASE_W-1:0] {
        EASE_LINEAR = 3'd0,
        EASE_IN     = 3'd1,
        EASE_OUT    = 3'd2,
        EASE_INOUT  = 3'd3,
        EASE_STEP   = 3'd4
    } ease_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_IDLE  = 2'd1,
        ST_ORDER = 2'd2
    } status_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_KEY_COUNT = 4'd0,
        CFG_DURATION  = 4'd1,
        CFG_LOOP      = 4'd2,
        CFG_KIND      = 4'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_ZERO,
        POS_SEEK,
        POS_TICK,
        POS_REM
    } pos_sel_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_LAST,
        PH_MID
    } scan_ph_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_LOAD,
        S_CHK0,
        S_CHK,
        S_CHKEND,
        S_STOP,
        S_SEEK,
        S_TICK,
        S_DIVM,
        S_TICKF,
        S_SCAN0,
        S_SCAN,
        S_DIVS,
        S_DIV,
        S_EASE1,
        S_EASE2,
        S_LERP1,
        S_LERP2,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] t;
        logic [VAL_W-1:0]     v;
        logic [EASE_W-1:0]    e;
    } key_t;

    typedef struct packed {
        logic     cap;
        logic     key_wr;
        logic     chk_start;
        logic     chk_step;
        logic     play_set;
        logic     play_clr;
        pos_sel_t pos_sel;
        logic     set_status;
        status_t  status;
        logic     tick_fin;
        logic     scan_start;
        logic     scan_step;
        logic     div_frac;
        logic     div_mod;
        logic     ease_mul;
        logic     ease_fin;
        logic     lerp_mul;
        logic     lerp_fin;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             playing;
        logic             apply;
        logic             chk_last;
        logic             chk_bad;
        logic             tick_mod;
        logic             scan_hit;
        logic             scan_single;
        logic             div_busy;
        logic             lerp_last;
        logic             out_free;
    } sts_t;

endpackage

>>> src/ktp_ram.sv
module ktp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/ktp_div.sv
module ktp_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ktp_pkg::NUM_W-1:0]      num,
    input  logic [ktp_pkg::TIME_BITS-1:0]  den,
    output logic                           busy,
    output logic [ktp_pkg::NUM_W-1:0]      quot,
    output logic [ktp_pkg::TIME_BITS-1:0]  rem
);

    localparam int CW = $clog2(ktp_pkg::NUM_W + 1);

    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [ktp_pkg::NUM_W-1:0]      q_reg, q_next;
    logic [ktp_pkg::TIME_BITS-1:0]  rem_reg, rem_next;
    logic [ktp_pkg::TIME_BITS-1:0]  den_reg, den_next;
    logic [ktp_pkg::TIME_BITS:0]    rem2;
    logic                           ge;

    assign rem2 = {rem_reg, q_reg[ktp_pkg::NUM_W-1]};
    assign ge   = rem2 >= {1'b0, den_reg};

    always_comb begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start) begin
            cnt_next = CW'(ktp_pkg::NUM_W);
            q_next   = num;
            rem_next = '0;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            q_next   = {q_reg[ktp_pkg::NUM_W-2:0], ge};
            rem_next = ge ? ktp_pkg::TIME_BITS'(rem2 - {1'b0, den_reg})
                          : rem2[ktp_pkg::TIME_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

>>> src/ktp_dp.sv
module ktp_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ktp_pkg::cmd_t                      cmd,
    output ktp_pkg::sts_t                      sts,
    input  logic                               cfg_we,
    input  logic [ktp_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [ktp_pkg::CFG_DW-1:0]         cfg_data,
    input  logic [ktp_pkg::REQ_W-1:0]          s_req_type,
    input  logic [ktp_pkg::IDX_W-1:0]          s_key_index,
    input  logic [ktp_pkg::TIME_BITS-1:0]      s_key_time,
    input  logic [ktp_pkg::VAL_W-1:0]          s_key_value,
    input  logic [ktp_pkg::EASE_W-1:0]         s_key_ease,
    input  logic [ktp_pkg::TIME_BITS-1:0]      s_time_arg,
    input  logic                               s_apply_now,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ktp_pkg::VAL_W-1:0]          m_sampled_value,
    output logic                               m_value_valid,
    output logic [ktp_pkg::STAT_W-1:0]         m_status,
    output logic                               m_finished,
    output logic [ktp_pkg::TIME_BITS-1:0]      m_playhead
);

    localparam int TB = ktp_pkg::TIME_BITS;
    localparam int AW = ktp_pkg::KEY_AW;
    localparam int QW = ktp_pkg::Q_W;

    // configuration
    logic [ktp_pkg::CNT_W-1:0] kc_reg;
    logic [TB-1:0]             dur_reg;
    logic                      loop_reg, kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kc_reg   <= ktp_pkg::CNT_W'(1);
            dur_reg  <= '0;
            loop_reg <= 1'b0;
            kind_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ktp_pkg::CFG_KEY_COUNT: kc_reg   <= cfg_data[ktp_pkg::CNT_W-1:0];
                ktp_pkg::CFG_DURATION:  dur_reg  <= cfg_data[TB-1:0];
                ktp_pkg::CFG_LOOP:      loop_reg <= cfg_data[0];
                ktp_pkg::CFG_KIND:      kind_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [AW-1:0] nm1;
    always_comb begin
        if (kc_reg == '0) begin
            nm1 = '0;
        end else if (kc_reg > ktp_pkg::CNT_W'(ktp_pkg::KEY_DEPTH)) begin
            nm1 = AW'(ktp_pkg::KEY_DEPTH - 1);
        end else begin
            nm1 = AW'(kc_reg - 1'b1);
        end
    end

    // captured word
    logic [ktp_pkg::REQ_W-1:0]  req_reg;
    logic [ktp_pkg::IDX_W-1:0]  idx_reg;
    ktp_pkg::key_t              kin_reg;
    logic [TB-1:0]              targ_reg;
    logic                       apply_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            req_reg   <= s_req_type;
            idx_reg   <= s_key_index;
            kin_reg   <= '{t: s_key_time, v: s_key_value, e: s_key_ease};
            targ_reg  <= s_time_arg;
            apply_reg <= s_apply_now;
        end
    end

    // key store
    logic [AW-1:0]  addr_reg, addr_next;
    ktp_pkg::key_t  rd;
    logic           ram_we;

    assign ram_we = cmd.key_wr && (32'(idx_reg) < ktp_pkg::KEY_DEPTH);

    ktp_ram #(
        .WIDTH($bits(ktp_pkg::key_t)),
        .DEPTH(ktp_pkg::KEY_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (kin_reg),
        .raddr (addr_next),
        .rdata (rd)
    );

    // playhead
    logic          play_reg;
    logic [TB-1:0] pos_reg, pos_next;
    logic [TB:0]   sum;
    logic          tick_mod;

    assign sum      = {1'b0, pos_reg} + {1'b0, targ_reg};
    assign tick_mod = (sum > {1'b0, dur_reg}) && loop_reg && (dur_reg != '0);

    // divider
    logic                       div_start, div_busy;
    logic [ktp_pkg::NUM_W-1:0]  div_num, div_quot;
    logic [TB-1:0]              div_den, div_rem;

    ktp_pkg::key_t  pa_reg, pb_reg, last_reg;
    ktp_pkg::scan_ph_t ph_reg;
    logic [TB-1:0]  span, pofs;

    assign span = pb_reg.t - pa_reg.t;
    assign pofs = pos_reg - pa_reg.t;

    always_comb begin
        div_start = cmd.div_frac || cmd.div_mod;
        if (cmd.div_mod) begin
            div_num = ktp_pkg::NUM_W'(sum);
            div_den = dur_reg;
        end else begin
            div_num = ({ktp_pkg::NUM_W'(pofs)} << ktp_pkg::FRAC_BITS)
                      + ktp_pkg::NUM_W'(span >> 1);
            div_den = span;
        end
    end

    ktp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    always_comb begin
        unique case (cmd.pos_sel)
            ktp_pkg::POS_ZERO: pos_next = '0;
            ktp_pkg::POS_SEEK: pos_next = (targ_reg < dur_reg) ? targ_reg : dur_reg;
            ktp_pkg::POS_TICK: pos_next = (sum > {1'b0, dur_reg}) ? dur_reg : sum[TB-1:0];
            ktp_pkg::POS_REM:  pos_next = div_rem;
            default:           pos_next = pos_reg;
        endcase
    end

    // check and scan
    logic chk_bad_reg;
    logic scan_hit, scan_single;
    logic [AW-1:0] nm2;

    assign nm2 = nm1 - 1'b1;

    always_comb begin
        scan_hit    = 1'b0;
        scan_single = 1'b0;
        addr_next   = addr_reg;
        if (cmd.chk_start || cmd.scan_start) begin
            addr_next = '0;
        end else if (cmd.chk_step) begin
            addr_next = addr_reg + 1'b1;
        end else if (cmd.scan_step) begin
            case (ph_reg)
                ktp_pkg::PH_FIRST: begin
                    if (pos_reg <= rd.t) begin
                        scan_hit    = 1'b1;
                        scan_single = 1'b1;
                    end else begin
                        addr_next = nm1;
                    end
                end
                ktp_pkg::PH_LAST: begin
                    if (pos_reg >= rd.t) begin
                        scan_hit    = 1'b1;
                        scan_single = 1'b1;
                    end else if (nm1 == AW'(1)) begin
                        scan_hit = 1'b1;
                    end else begin
                        addr_next = AW'(1);
                    end
                end
                default: begin
                    if (pos_reg < rd.t || addr_reg == nm2) begin
                        scan_hit = 1'b1;
                    end else begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    // easing and interpolation
    logic [QW-1:0]   u, v, ma, mb, qm, e_reg, u_reg;
    logic [2*QW-1:0] eprod_reg;
    logic [2*QW-1:0] qm_full;

    assign u = (div_quot > ktp_pkg::NUM_W'(ktp_pkg::Q_ONE)) ? ktp_pkg::Q_ONE
                                                            : div_quot[QW-1:0];
    assign v = ktp_pkg::Q_ONE - u;

    always_comb begin
        case (pb_reg.e)
            ktp_pkg::EASE_OUT: begin
                ma = v;
                mb = v;
            end
            ktp_pkg::EASE_INOUT: begin
                if (u < ktp_pkg::Q_HALF) begin
                    ma = u << 1;
                    mb = u;
                end else begin
                    ma = v << 1;
                    mb = v;
                end
            end
            default: begin
                ma = u;
                mb = u;
            end
        endcase
    end

    assign qm_full = (eprod_reg + (2*QW)'(ktp_pkg::Q_HALF)) >> ktp_pkg::FRAC_BITS;
    assign qm      = qm_full[QW-1:0];

    logic [QW-1:0] e_next;
    always_comb begin
        case (pb_reg.e)
            ktp_pkg::EASE_IN:    e_next = qm;
            ktp_pkg::EASE_OUT:   e_next = ktp_pkg::Q_ONE - qm;
            ktp_pkg::EASE_INOUT: e_next = (u_reg < ktp_pkg::Q_HALF) ? qm
                                                                     : ktp_pkg::Q_ONE - qm;
            ktp_pkg::EASE_STEP:  e_next = '0;
            default:             e_next = u_reg;
        endcase
    end

    logic [ktp_pkg::LANE_SW-1:0]      lane_reg;
    logic signed [ktp_pkg::DIFF_W-1:0] xs, ys, ds, x_reg;
    logic signed [QW:0]                es;
    logic signed [ktp_pkg::PROD_W-1:0] mprod_reg;
    logic [ktp_pkg::LANE_W-1:0]        xa, yb;

    assign xa = pa_reg.v[lane_reg*ktp_pkg::LANE_W +: ktp_pkg::LANE_W];
    assign yb = pb_reg.v[lane_reg*ktp_pkg::LANE_W +: ktp_pkg::LANE_W];
    assign es = $signed({1'b0, e_reg});

    always_comb begin
        if (kind_reg) begin
            xs = $signed({{(ktp_pkg::DIFF_W-ktp_pkg::LANE_W){1'b0}}, xa});
            ys = $signed({{(ktp_pkg::DIFF_W-ktp_pkg::LANE_W){1'b0}}, yb});
        end else begin
            xs = $signed({{(ktp_pkg::DIFF_W-ktp_pkg::VAL_W){pa_reg.v[ktp_pkg::VAL_W-1]}},
                          pa_reg.v});
            ys = $signed({{(ktp_pkg::DIFF_W-ktp_pkg::VAL_W){pb_reg.v[ktp_pkg::VAL_W-1]}},
                          pb_reg.v});
        end
        ds = ys - xs;
    end

    logic signed [ktp_pkg::SUM_W-1:0] xw, vsum, rs;
    logic [ktp_pkg::SUM_W-1:0]        mag, rnd;
    logic                             neg;
    logic [ktp_pkg::LANE_W-1:0]       lane_out;

    always_comb begin
        xw   = ktp_pkg::SUM_W'(x_reg);
        vsum = (xw <<< ktp_pkg::FRAC_BITS) + ktp_pkg::SUM_W'(mprod_reg);
        neg  = vsum[ktp_pkg::SUM_W-1];
        mag  = neg ? ktp_pkg::SUM_W'(-vsum) : ktp_pkg::SUM_W'(vsum);
        rnd  = (mag + ktp_pkg::SUM_W'(ktp_pkg::Q_HALF)) >> ktp_pkg::FRAC_BITS;
        rs   = neg ? -$signed(rnd) : $signed(rnd);
        if (rs < 0) begin
            lane_out = '0;
        end else if (rs > ktp_pkg::SUM_W'(255)) begin
            lane_out = '1;
        end else begin
            lane_out = rs[ktp_pkg::LANE_W-1:0];
        end
    end

    // result
    logic [ktp_pkg::VAL_W-1:0]  rval_reg;
    logic                       rvv_reg, rfin_reg;
    logic [ktp_pkg::STAT_W-1:0] rstat_reg;
    logic                       mv_reg;
    logic [ktp_pkg::VAL_W-1:0]  mval_reg;
    logic                       mvv_reg, mfin_reg;
    logic [ktp_pkg::STAT_W-1:0] mstat_reg;
    logic [TB-1:0]              mpos_reg;
    logic                       tick_done;

    assign tick_done = !loop_reg && (pos_reg >= dur_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_reg <= 1'b0;
            pos_reg  <= '0;
            mv_reg   <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (cmd.play_set) begin
                play_reg <= 1'b1;
            end else if (cmd.play_clr || (cmd.tick_fin && tick_done)) begin
                play_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        if (cmd.cap) begin
            rval_reg  <= '0;
            rvv_reg   <= 1'b0;
            rfin_reg  <= 1'b0;
            rstat_reg <= ktp_pkg::ST_OK;
        end
        if (cmd.set_status) begin
            rstat_reg <= cmd.status;
        end
        if (cmd.tick_fin) begin
            rfin_reg <= tick_done;
        end
        if (cmd.chk_start) begin
            chk_bad_reg <= 1'b0;
        end
        if (cmd.chk_step) begin
            if (addr_reg != '0 && rd.t < pa_reg.t) begin
                chk_bad_reg <= 1'b1;
            end
            pa_reg <= rd;
        end
        if (cmd.scan_start) begin
            ph_reg <= ktp_pkg::PH_FIRST;
        end
        if (cmd.scan_step) begin
            case (ph_reg)
                ktp_pkg::PH_FIRST: begin
                    pa_reg <= rd;
                    ph_reg <= ktp_pkg::PH_LAST;
                end
                ktp_pkg::PH_LAST: begin
                    last_reg <= rd;
                    pb_reg   <= rd;
                    ph_reg   <= ktp_pkg::PH_MID;
                end
                default: begin
                    if (pos_reg < rd.t) begin
                        pb_reg <= rd;
                    end else begin
                        pa_reg <= rd;
                        pb_reg <= last_reg;
                    end
                end
            endcase
            if (scan_single) begin
                rval_reg <= rd.v;
                rvv_reg  <= 1'b1;
            end
        end
        if (cmd.ease_mul) begin
            eprod_reg <= ma * mb;
            u_reg     <= u;
        end
        if (cmd.ease_fin) begin
            e_reg    <= e_next;
            lane_reg <= '0;
        end
        if (cmd.lerp_mul) begin
            mprod_reg <= ds * es;
            x_reg     <= xs;
        end
        if (cmd.lerp_fin) begin
            if (kind_reg) begin
                rval_reg[lane_reg*ktp_pkg::LANE_W +: ktp_pkg::LANE_W] <= lane_out;
            end else begin
                rval_reg <= rs[ktp_pkg::VAL_W-1:0];
            end
            rvv_reg  <= 1'b1;
            lane_reg <= lane_reg + 1'b1;
        end
        if (cmd.out_load) begin
            mval_reg  <= rval_reg;
            mvv_reg   <= rvv_reg;
            mstat_reg <= rstat_reg;
            mfin_reg  <= rfin_reg;
            mpos_reg  <= pos_reg;
        end
    end

    always_comb begin
        sts.req         = req_reg;
        sts.playing     = play_reg;
        sts.apply       = apply_reg;
        sts.chk_last    = addr_reg == nm1;
        sts.chk_bad     = chk_bad_reg;
        sts.tick_mod    = tick_mod;
        sts.scan_hit    = scan_hit;
        sts.scan_single = scan_single;
        sts.div_busy    = div_busy;
        sts.lerp_last   = !kind_reg || (lane_reg == ktp_pkg::LANE_SW'(ktp_pkg::LANES - 1));
        sts.out_free    = !mv_reg || m_ready;
    end

    assign m_valid         = mv_reg;
    assign m_sampled_value = mval_reg;
    assign m_value_valid   = mvv_reg;
    assign m_status        = mstat_reg;
    assign m_finished      = mfin_reg;
    assign m_playhead      = mpos_reg;

endmodule

>>> src/ktp_ctrl.sv
module ktp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ktp_pkg::sts_t  sts,
    output ktp_pkg::cmd_t  cmd
);

    ktp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ktp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ktp_pkg::S_IDLE:   if (s_valid) state_next = ktp_pkg::S_DISP;
            ktp_pkg::S_DISP: begin
                case (sts.req)
                    ktp_pkg::REQ_LOAD: state_next = ktp_pkg::S_LOAD;
                    ktp_pkg::REQ_PLAY: state_next = ktp_pkg::S_CHK0;
                    ktp_pkg::REQ_STOP: state_next = ktp_pkg::S_STOP;
                    ktp_pkg::REQ_SEEK: state_next = ktp_pkg::S_SEEK;
                    ktp_pkg::REQ_TICK: state_next = ktp_pkg::S_TICK;
                    default:           state_next = ktp_pkg::S_IDLE;
                endcase
            end
            ktp_pkg::S_LOAD:   state_next = ktp_pkg::S_IDLE;
            ktp_pkg::S_CHK0:   state_next = ktp_pkg::S_CHK;
            ktp_pkg::S_CHK:    if (sts.chk_last) state_next = ktp_pkg::S_CHKEND;
            ktp_pkg::S_CHKEND: state_next = sts.chk_bad ? ktp_pkg::S_RESULT : ktp_pkg::S_SCAN0;
            ktp_pkg::S_STOP:   state_next = ktp_pkg::S_RESULT;
            ktp_pkg::S_SEEK: begin
                if (sts.playing && sts.apply) begin
                    state_next = ktp_pkg::S_SCAN0;
                end else begin
                    state_next = ktp_pkg::S_RESULT;
                end
            end
            ktp_pkg::S_TICK: begin
                if (!sts.playing) begin
                    state_next = ktp_pkg::S_RESULT;
                end else if (sts.tick_mod) begin
                    state_next = ktp_pkg::S_DIVM;
                end else begin
                    state_next = ktp_pkg::S_TICKF;
                end
            end
            ktp_pkg::S_DIVM:   if (!sts.div_busy) state_next = ktp_pkg::S_TICKF;
            ktp_pkg::S_TICKF:  state_next = ktp_pkg::S_SCAN0;
            ktp_pkg::S_SCAN0:  state_next = ktp_pkg::S_SCAN;
            ktp_pkg::S_SCAN: begin
                if (sts.scan_hit) begin
                    state_next = sts.scan_single ? ktp_pkg::S_RESULT : ktp_pkg::S_DIVS;
                end
            end
            ktp_pkg::S_DIVS:   state_next = ktp_pkg::S_DIV;
            ktp_pkg::S_DIV:    if (!sts.div_busy) state_next = ktp_pkg::S_EASE1;
            ktp_pkg::S_EASE1:  state_next = ktp_pkg::S_EASE2;
            ktp_pkg::S_EASE2:  state_next = ktp_pkg::S_LERP1;
            ktp_pkg::S_LERP1:  state_next = ktp_pkg::S_LERP2;
            ktp_pkg::S_LERP2:  state_next = sts.lerp_last ? ktp_pkg::S_RESULT : ktp_pkg::S_LERP1;
            ktp_pkg::S_RESULT: if (sts.out_free) state_next = ktp_pkg::S_IDLE;
            default:           state_next = ktp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.pos_sel = ktp_pkg::POS_HOLD;
        cmd.status  = ktp_pkg::ST_OK;
        s_ready     = 1'b0;
        unique case (state_reg)
            ktp_pkg::S_IDLE: begin
                s_ready = 1'b1;
                cmd.cap = s_valid;
            end
            ktp_pkg::S_LOAD:  cmd.key_wr = 1'b1;
            ktp_pkg::S_CHK0:  cmd.chk_start = 1'b1;
            ktp_pkg::S_CHK:   cmd.chk_step = 1'b1;
            ktp_pkg::S_CHKEND: begin
                if (sts.chk_bad) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ktp_pkg::ST_ORDER;
                end else begin
                    cmd.play_set = 1'b1;
                    cmd.pos_sel  = ktp_pkg::POS_ZERO;
                end
            end
            ktp_pkg::S_STOP: begin
                cmd.play_clr = 1'b1;
                cmd.pos_sel  = ktp_pkg::POS_ZERO;
            end
            ktp_pkg::S_SEEK: begin
                if (!sts.playing) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ktp_pkg::ST_IDLE;
                end else begin
                    cmd.pos_sel = ktp_pkg::POS_SEEK;
                end
            end
            ktp_pkg::S_TICK: begin
                if (sts.playing) begin
                    if (sts.tick_mod) begin
                        cmd.div_mod = 1'b1;
                    end else begin
                        cmd.pos_sel = ktp_pkg::POS_TICK;
                    end
                end
            end
            ktp_pkg::S_DIVM:   if (!sts.div_busy) cmd.pos_sel = ktp_pkg::POS_REM;
            ktp_pkg::S_TICKF:  cmd.tick_fin = 1'b1;
            ktp_pkg::S_SCAN0:  cmd.scan_start = 1'b1;
            ktp_pkg::S_SCAN:   cmd.scan_step = 1'b1;
            ktp_pkg::S_DIVS:   cmd.div_frac = 1'b1;
            ktp_pkg::S_EASE1:  cmd.ease_mul = 1'b1;
            ktp_pkg::S_EASE2:  cmd.ease_fin = 1'b1;
            ktp_pkg::S_LERP1:  cmd.lerp_mul = 1'b1;
            ktp_pkg::S_LERP2:  cmd.lerp_fin = 1'b1;
            ktp_pkg::S_RESULT: cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> src/keyframe_track_player.sv
// Keyframe track player: one track of up to 16 keys plus a playhead, one request
// word at a time. A key load needs no result slot; stop, a refused seek or a tick
// while stopped wait only for the result slot. A sample walks the key memory at
// one key per cycle through its single registered read port, then runs the
// bit-serial divider for the fraction and the ease and blend steps, the blend
// once per lane for color. Play first sweeps all n keys for ordering; a looping
// tick that wraps adds another divider pass for the modulo. The next word is
// taken while a finished result still waits in the output register.
module keyframe_track_player (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ktp_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [ktp_pkg::CFG_DW-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ktp_pkg::REQ_W-1:0]          s_req_type,
    input  logic [ktp_pkg::IDX_W-1:0]          s_key_index,
    input  logic [ktp_pkg::TIME_BITS-1:0]      s_key_time,
    input  logic [ktp_pkg::VAL_W-1:0]          s_key_value,
    input  logic [ktp_pkg::EASE_W-1:0]         s_key_ease,
    input  logic [ktp_pkg::TIME_BITS-1:0]      s_time_arg,
    input  logic                               s_apply_now,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ktp_pkg::VAL_W-1:0]          m_sampled_value,
    output logic                               m_value_valid,
    output logic [ktp_pkg::STAT_W-1:0]         m_status,
    output logic                               m_finished,
    output logic [ktp_pkg::TIME_BITS-1:0]      m_playhead
);

    ktp_pkg::cmd_t cmd;
    ktp_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ktp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ktp_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_req_type      (s_req_type),
        .s_key_index     (s_key_index),
        .s_key_time      (s_key_time),
        .s_key_value     (s_key_value),
        .s_key_ease      (s_key_ease),
        .s_time_arg      (s_time_arg),
        .s_apply_now     (s_apply_now),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sampled_value (m_sampled_value),
        .m_value_valid   (m_value_valid),
        .m_status        (m_status),
        .m_finished      (m_finished),
        .m_playhead      (m_playhead)
    );

endmodule

>>> src/ktp_checker.sv
module ktp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [ktp_pkg::VAL_W-1:0]      m_sampled_value,
    input logic                           m_value_valid,
    input logic [ktp_pkg::STAT_W-1:0]     m_status,
    input logic                           m_finished,
    input logic [ktp_pkg::TIME_BITS-1:0]  m_playhead
);

    // no sample means a zero value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_value_valid |-> m_sampled_value == '0)
        else $error("value without sample");

    // a refused request never carries a sample
    a_status_nosample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ktp_pkg::ST_OK |-> !m_value_valid)
        else $error("sample with error status");

    // end of clip comes with a sample of the final frame
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> m_value_valid && m_status == ktp_pkg::ST_OK)
        else $error("finish without sample");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sampled_value)
                                && $stable(m_playhead))
        else $error("result word changed while stalled");

endmodule

bind keyframe_track_player ktp_checker u_ktp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_sampled_value (m_sampled_value),
    .m_value_valid   (m_value_valid),
    .m_status        (m_status),
    .m_finished      (m_finished),
    .m_playhead      (m_playhead)
);

>>> verif/tb_keyframe_track_player.sv
`timescale 1ns / 1ps

module tb_keyframe_track_player;

    localparam logic [ktp_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [ktp_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 700;
    localparam int PHASE_ITEMS   = 72;

    typedef struct {
        logic [ktp_pkg::REQ_W-1:0]     req;
        logic [ktp_pkg::IDX_W-1:0]     idx;
        logic [ktp_pkg::TIME_BITS-1:0] ktime;
        logic [ktp_pkg::VAL_W-1:0]     kval;
        logic [ktp_pkg::EASE_W-1:0]    kease;
        logic [ktp_pkg::TIME_BITS-1:0] targ;
        logic                          apply;
    } track_word_t;

    typedef struct {
        logic [ktp_pkg::VAL_W-1:0]     value;
        logic                          vvalid;
        logic [ktp_pkg::STAT_W-1:0]    status;
        logic                          fin;
        logic [ktp_pkg::TIME_BITS-1:0] head;
    } sample_word_t;

    class track_scoreboard;
        logic [ktp_pkg::TIME_BITS-1:0] k_time[ktp_pkg::KEY_DEPTH];
        logic [ktp_pkg::VAL_W-1:0]     k_val[ktp_pkg::KEY_DEPTH];
        logic [ktp_pkg::EASE_W-1:0]    k_ease[ktp_pkg::KEY_DEPTH];
        bit                            playing;
        longint unsigned               pos;
        logic [ktp_pkg::CNT_W-1:0]     key_cnt = 1;
        logic [ktp_pkg::TIME_BITS-1:0] dur = 0;
        bit                            looping = 0;
        bit                            rgba = 0;
        sample_word_t                  sample_q[$];

        function void write_reg(ktp_pkg::cfg_idx_t idx, logic [ktp_pkg::CFG_DW-1:0] d);
            case (idx)
                ktp_pkg::CFG_KEY_COUNT: key_cnt = d[ktp_pkg::CNT_W-1:0];
                ktp_pkg::CFG_DURATION:  dur = d[ktp_pkg::TIME_BITS-1:0];
                ktp_pkg::CFG_LOOP:      looping = d[0];
                ktp_pkg::CFG_KIND:      rgba = d[0];
                default: ;
            endcase
        endfunction

        function int unsigned keys_used();
            if (key_cnt == 0) return 1;
            if (key_cnt > ktp_pkg::KEY_DEPTH) return ktp_pkg::KEY_DEPTH;
            return key_cnt;
        endfunction

        function longint unsigned qmul(longint unsigned a, longint unsigned b);
            return (a * b + (64'd1 << (ktp_pkg::FRAC_BITS - 1))) >> ktp_pkg::FRAC_BITS;
        endfunction

        function longint unsigned shape(longint unsigned u, logic [ktp_pkg::EASE_W-1:0] mode);
            longint unsigned one;
            longint unsigned v;
            one = 64'd1 << ktp_pkg::FRAC_BITS;
            v = one - u;
            case (mode)
                ktp_pkg::EASE_IN:    return qmul(u, u);
                ktp_pkg::EASE_OUT:   return one - qmul(v, v);
                ktp_pkg::EASE_INOUT: return (u < (one >> 1)) ? qmul(2 * u, u)
                                                             : one - qmul(2 * v, v);
                ktp_pkg::EASE_STEP:  return 0;
                default:             return u;
            endcase
        endfunction

        function longint blend(longint x, longint y, longint unsigned e);
            longint d;
            longint h;
            h = longint'(1) << (ktp_pkg::FRAC_BITS - 1);
            d = x * (longint'(1) << ktp_pkg::FRAC_BITS) + (y - x) * longint'(e);
            if (d >= 0) return (d + h) >>> ktp_pkg::FRAC_BITS;
            return -((-d + h) >>> ktp_pkg::FRAC_BITS);
        endfunction

        function logic [ktp_pkg::VAL_W-1:0] value_at(longint unsigned p);
            int unsigned n;
            int unsigned i;
            longint unsigned ta;
            longint unsigned span;
            longint unsigned u;
            longint unsigned e;
            longint c;
            logic [ktp_pkg::VAL_W-1:0] a;
            logic [ktp_pkg::VAL_W-1:0] b;
            logic [ktp_pkg::VAL_W-1:0] res;
            n = keys_used();
            if (p <= k_time[0]) return k_val[0];
            if (p >= k_time[n-1]) return k_val[n-1];
            for (i = 1; i < n - 1; i++)
                if (p < k_time[i]) break;
            ta = k_time[i-1];
            span = longint'(k_time[i]) - ta;
            u = (((p - ta) << ktp_pkg::FRAC_BITS) + span / 2) / span;
            if (u > (64'd1 << ktp_pkg::FRAC_BITS)) u = 64'd1 << ktp_pkg::FRAC_BITS;
            e = shape(u, k_ease[i]);
            a = k_val[i-1];
            b = k_val[i];
            res = '0;
            if (rgba) begin
                for (int s = 0; s < ktp_pkg::LANES; s++) begin
                    c = blend(a[s*ktp_pkg::LANE_W +: ktp_pkg::LANE_W],
                              b[s*ktp_pkg::LANE_W +: ktp_pkg::LANE_W], e);
                    if (c < 0) c = 0;
                    if (c > 255) c = 255;
                    res[s*ktp_pkg::LANE_W +: ktp_pkg::LANE_W] = c[ktp_pkg::LANE_W-1:0];
                end
            end else begin
                c = blend(longint'($signed(a)), longint'($signed(b)), e);
                res = c[ktp_pkg::VAL_W-1:0];
            end
            return res;
        endfunction

        function void note_input(track_word_t w);
            sample_word_t r;
            bit ok;
            r = '{default: '0};
            case (w.req)
                ktp_pkg::REQ_LOAD: begin
                    k_time[w.idx] = w.ktime;
                    k_val[w.idx] = w.kval;
                    k_ease[w.idx] = w.kease;
                    return;
                end
                ktp_pkg::REQ_PLAY: begin
                    ok = 1;
                    for (int i = 1; i < keys_used(); i++)
                        if (k_time[i] < k_time[i-1]) ok = 0;
                    if (ok) begin
                        playing = 1;
                        pos = 0;
                        r.value = value_at(0);
                        r.vvalid = 1;
                    end else begin
                        r.status = ktp_pkg::ST_ORDER;
                    end
                end
                ktp_pkg::REQ_STOP: begin
                    playing = 0;
                    pos = 0;
                end
                ktp_pkg::REQ_SEEK: begin
                    if (!playing) begin
                        r.status = ktp_pkg::ST_IDLE;
                    end else begin
                        pos = (w.targ < dur) ? w.targ : dur;
                        if (w.apply) begin
                            r.value = value_at(pos);
                            r.vvalid = 1;
                        end
                    end
                end
                ktp_pkg::REQ_TICK: begin
                    if (playing) begin
                        pos += w.targ;
                        if (pos > dur) begin
                            if (looping && dur > 0) pos %= dur;
                            else pos = dur;
                        end
                        r.fin = !looping && pos >= dur;
                        r.value = value_at(pos);
                        r.vvalid = 1;
                        if (r.fin) playing = 0;
                    end
                end
                default: return;
            endcase
            r.head = pos[ktp_pkg::TIME_BITS-1:0];
            sample_q = {sample_q, r};
        endfunction

        function string check_result(sample_word_t got);
            sample_word_t x;
            if (sample_q.size() == 0)
                return $sformatf("unexpected word: value %h head %0d", got.value, got.head);
            x = sample_q.pop_front();
            if (got.value !== x.value || got.vvalid !== x.vvalid || got.status !== x.status ||
                got.fin !== x.fin || got.head !== x.head)
                return $sformatf({"got v=%h vv=%b st=%0d fin=%b ph=%0d",
                                  " exp v=%h vv=%b st=%0d fin=%b ph=%0d"},
                    got.value, got.vvalid, got.status, got.fin, got.head,
                    x.value, x.vvalid, x.status, x.fin, x.head);
            return "";
        endfunction

        function int pending();
            return sample_q.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ktp_pkg::CFG_AW-1:0]    cfg_index;
    logic [ktp_pkg::CFG_DW-1:0]    cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [ktp_pkg::REQ_W-1:0]     s_req_type;
    logic [ktp_pkg::IDX_W-1:0]     s_key_index;
    logic [ktp_pkg::TIME_BITS-1:0] s_key_time;
    logic [ktp_pkg::VAL_W-1:0]     s_key_value;
    logic [ktp_pkg::EASE_W-1:0]    s_key_ease;
    logic [ktp_pkg::TIME_BITS-1:0] s_time_arg;
    logic                          s_apply_now;
    logic                          m_valid;
    logic                          m_ready;
    logic [ktp_pkg::VAL_W-1:0]     m_sampled_value;
    logic                          m_value_valid;
    logic [ktp_pkg::STAT_W-1:0]    m_status;
    logic                          m_finished;
    logic [ktp_pkg::TIME_BITS-1:0] m_playhead;

    keyframe_track_player dut (.*);

    track_scoreboard sb = new;
    int errors = 0;
    int tx_pct = 0;
    int rx_pct = 0;
    int hold_tok = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // receiver: random stalls plus one long hold
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_tok != hold_seen) begin
                hold_seen = hold_tok;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 0;
            end else begin
                m_ready = ($urandom_range(99) >= rx_pct);
            end
        end
    end

    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_valid && m_ready) begin
            msg = sb.check_result('{m_sampled_value, m_value_valid, m_status, m_finished,
                                    m_playhead});
            if (msg != "") report_mismatch(msg);
        end
    end

    task automatic write_reg(ktp_pkg::cfg_idx_t idx, logic [ktp_pkg::CFG_DW-1:0] d);
        @(negedge aclk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send(track_word_t w);
        @(negedge aclk);
        while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid = 1;
        s_req_type = w.req;
        s_key_index = w.idx;
        s_key_time = w.ktime;
        s_key_value = w.kval;
        s_key_ease = w.kease;
        s_time_arg = w.targ;
        s_apply_now = w.apply;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic track_word_t noise_word(logic [ktp_pkg::REQ_W-1:0] req);
        track_word_t w;
        w.req = req;
        w.idx = ktp_pkg::IDX_W'($urandom);
        w.ktime = ktp_pkg::TIME_BITS'($urandom);
        w.kval = $urandom;
        w.kease = ktp_pkg::EASE_W'($urandom);
        w.targ = ktp_pkg::TIME_BITS'($urandom);
        w.apply = 1'($urandom);
        return w;
    endfunction

    function automatic logic [ktp_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic track_word_t load_word(int idx, int t, logic [ktp_pkg::VAL_W-1:0] v,
                                              int e);
        track_word_t w;
        w = noise_word(ktp_pkg::REQ_LOAD);
        w.idx = ktp_pkg::IDX_W'(idx);
        w.ktime = ktp_pkg::TIME_BITS'(t);
        w.kval = v;
        w.kease = ktp_pkg::EASE_W'(e);
        return w;
    endfunction

    function automatic track_word_t ctrl_word(logic [ktp_pkg::REQ_W-1:0] req, int arg, bit ap);
        track_word_t w;
        w = noise_word(req);
        w.targ = ktp_pkg::TIME_BITS'(arg);
        w.apply = ap;
        return w;
    endfunction

    function automatic track_word_t random_word(int dur);
        int r;
        int hi;
        int arg;
        r = $urandom_range(99);
        hi = dur + dur / 4 + 1;
        if (hi > 65535) hi = 65535;
        if (r < 6)
            return load_word($urandom_range(15), $urandom_range(0, hi), rand_value(),
                             $urandom_range(7));
        if (r < 12) return ctrl_word(ktp_pkg::REQ_PLAY, $urandom, 1'($urandom));
        if (r < 15) return ctrl_word(ktp_pkg::REQ_STOP, $urandom, 1'($urandom));
        if (r < 42) begin
            arg = ($urandom_range(9) == 0) ? 65535 : $urandom_range(0, hi);
            return ctrl_word(ktp_pkg::REQ_SEEK, arg, 1'($urandom));
        end
        if (r < 97) begin
            arg = ($urandom_range(9) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, dur / 6 + 2);
            return ctrl_word(ktp_pkg::REQ_TICK, arg, 1'($urandom));
        end
        return noise_word(ktp_pkg::REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)));
    endfunction

    initial begin
        int p_cnt[8]  = '{16, 1, 0, 5, 16, 31, 2, 16};
        int p_dur[8]  = '{1000, 65535, 300, 0, 5000, 700, 65535, 37};
        bit p_loop[8] = '{0, 1, 1, 1, 0, 1, 0, 0};
        bit p_kind[8] = '{0, 1, 0, 1, 1, 0, 1, 0};
        int t;
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 0;
        s_req_type = '0;
        s_key_index = '0;
        s_key_time = '0;
        s_key_value = '0;
        s_key_ease = '0;
        s_time_arg = '0;
        s_apply_now = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: all slots written with extremes, every request, corner cases
        write_reg(ktp_pkg::CFG_KEY_COUNT, ktp_pkg::CFG_DW'(16));
        write_reg(ktp_pkg::CFG_DURATION, ktp_pkg::CFG_DW'(1000));
        write_reg(ktp_pkg::CFG_LOOP, '0);
        write_reg(ktp_pkg::CFG_KIND, '0);
        send(ctrl_word(ktp_pkg::REQ_SEEK, 5, 1'b1));
        send(ctrl_word(ktp_pkg::REQ_TICK, 7, 1'b1));
        for (int i = 0; i < ktp_pkg::KEY_DEPTH; i++)
            send(load_word(i, (i == 15) ? 65535 : i * 60, (i % 2) ? 32'h8000_0000
                           : 32'h7FFF_FFFF, i % 8));
        send(ctrl_word(ktp_pkg::REQ_PLAY, 0, 1'b0));
        send(ctrl_word(ktp_pkg::REQ_SEEK, 65535, 1'b0));
        send(ctrl_word(ktp_pkg::REQ_SEEK, 95, 1'b1));
        send(ctrl_word(ktp_pkg::REQ_TICK, 65535, 1'b1));
        send(ctrl_word(ktp_pkg::REQ_STOP, 0, 1'b0));
        send(noise_word(REQ_UNUSED_FIRST));
        send(noise_word(REQ_UNUSED_LAST));
        send(load_word(1, 65535, 32'h0, ktp_pkg::EASE_LINEAR));
        send(ctrl_word(ktp_pkg::REQ_PLAY, 0, 1'b0));
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            tx_pct = (ph % 4 == 1) ? 62 : (ph % 4 == 3) ? 20 : 0;
            rx_pct = (ph % 4 == 2) ? 62 : (ph % 4 == 3) ? 20 : 0;
            write_reg(ktp_pkg::CFG_KEY_COUNT, ktp_pkg::CFG_DW'(p_cnt[ph]));
            write_reg(ktp_pkg::CFG_DURATION, ktp_pkg::CFG_DW'(p_dur[ph]));
            write_reg(ktp_pkg::CFG_LOOP, ktp_pkg::CFG_DW'(p_loop[ph]));
            write_reg(ktp_pkg::CFG_KIND, ktp_pkg::CFG_DW'(p_kind[ph]));
            t = 0;
            for (int i = 0; i < ktp_pkg::KEY_DEPTH; i++) begin
                send(load_word(i, t, rand_value(), $urandom_range(7)));
                t += $urandom_range(0, p_dur[ph] / 12 + 1);
                if (t > 65535) t = 65535;
            end
            send(ctrl_word(ktp_pkg::REQ_PLAY, 0, 1'b0));
            if (ph == 2) hold_tok++;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send(random_word(p_dur[ph]));
            settle();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
